// ----- src/obc_pkg.sv -----
// Shared types and constants of the object box collision search block.
// Depends on nothing; every other file of the block but obc_checker uses it.
package obc_pkg;

  localparam int ID_W   = 8;
  localparam int KIND_W = 6;
  localparam int IDX_W  = 6;
  localparam int X_W    = 16;
  localparam int Y_W    = 8;
  localparam int BOX_W  = 8;

  typedef enum logic [1:0] {
    CMD_LOAD_SLOT = 2'd0,
    CMD_LOAD_SIZE = 2'd1,
    CMD_QUERY     = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WALK   = 5'b00010,
    ST_FLUSH1 = 5'b00100,
    ST_FLUSH2 = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
  } slot_t;

  typedef struct packed {
    logic accept;
    logic start_query;
    logic issue;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic last_slot;
    logic out_full;
  } sts_t;

endpackage

// ----- src/obc_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
// Depends on obc_pkg for the field widths.
interface obc_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [obc_pkg::IDX_W-1:0]    index;
  logic [obc_pkg::ID_W-1:0]     object_id;
  logic [obc_pkg::KIND_W-1:0]   obj_kind;
  logic                         occupied;
  logic [obc_pkg::X_W-1:0]      pos_x;
  logic [obc_pkg::Y_W-1:0]      pos_y;
  logic [obc_pkg::BOX_W-1:0]    box_width;
  logic [obc_pkg::BOX_W-1:0]    box_height;

  modport source(output valid, cmd, index, object_id, obj_kind, occupied, pos_x, pos_y,
                 box_width, box_height, input ready);
  modport sink(input valid, cmd, index, object_id, obj_kind, occupied, pos_x, pos_y,
               box_width, box_height, output ready);
endinterface

interface obc_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source(output valid, hit, input ready);
  modport sink(input valid, hit, output ready);
endinterface

// ----- src/obc_ctrl.sv -----
// Controller state machine: accepts beats, sequences the slot walk and the result.
// Depends on obc_pkg for the state, command and status types.
module obc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_cmd,
  input  logic          out_ready,
  input  obc_pkg::sts_t sts,
  output logic          in_ready,
  output obc_pkg::ctl_t ctl
);

  obc_pkg::state_t state_r, state_nxt;

  always_comb begin
    in_ready         = (state_r == obc_pkg::ST_IDLE);
    ctl.accept       = in_valid && in_ready;
    ctl.start_query  = ctl.accept && (in_cmd == obc_pkg::CMD_QUERY);
    ctl.issue        = (state_r == obc_pkg::ST_WALK);
    ctl.out_load     = (state_r == obc_pkg::ST_RESULT) && (!sts.out_full || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      obc_pkg::ST_IDLE: begin
        if (ctl.start_query) begin
          state_nxt = obc_pkg::ST_WALK;
        end else if (ctl.accept) begin
          state_nxt = obc_pkg::ST_RESULT;
        end
      end
      obc_pkg::ST_WALK: begin
        if (sts.last_slot) begin
          state_nxt = obc_pkg::ST_FLUSH1;
        end
      end
      obc_pkg::ST_FLUSH1: begin
        state_nxt = obc_pkg::ST_FLUSH2;
      end
      obc_pkg::ST_FLUSH2: begin
        state_nxt = obc_pkg::ST_RESULT;
      end
      obc_pkg::ST_RESULT: begin
        if (ctl.out_load) begin
          state_nxt = obc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = obc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/obc_datapath.sv -----
// Datapath: slot and size memories, three-stage slot walk pipeline and result register.
// Depends on obc_pkg; driven by the command struct of obc_ctrl.
module obc_datapath #(
  parameter int ACTIVE_SLOTS = 16,
  parameter int TYPE_COUNT   = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  obc_pkg::ctl_t                 ctl,
  input  logic [1:0]                    in_cmd,
  input  logic [obc_pkg::IDX_W-1:0]     in_index,
  input  logic [obc_pkg::ID_W-1:0]      in_object_id,
  input  logic [obc_pkg::KIND_W-1:0]    in_obj_kind,
  input  logic                          in_occupied,
  input  logic [obc_pkg::X_W-1:0]       in_pos_x,
  input  logic [obc_pkg::Y_W-1:0]       in_pos_y,
  input  logic [obc_pkg::BOX_W-1:0]     in_box_width,
  input  logic [obc_pkg::BOX_W-1:0]     in_box_height,
  input  logic                          out_ready,
  output obc_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic                          out_hit
);

  localparam int SLOT_AW    = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int SIZE_DEPTH = (TYPE_COUNT < 64) ? TYPE_COUNT : 64;
  localparam int SIZE_AW    = $clog2(SIZE_DEPTH);
  localparam int BW         = obc_pkg::BOX_W;

  obc_pkg::slot_t          slot_mem [ACTIVE_SLOTS];
  logic [2*BW-1:0]         size_mem [SIZE_DEPTH];
  logic [ACTIVE_SLOTS-1:0] occ_r;

  logic                       slot_idx_ok, size_idx_ok;
  logic [obc_pkg::KIND_W-1:0] size_rkind;
  logic                       rkind_ok;

  logic [SLOT_AW-1:0]         ptr_r;
  logic [obc_pkg::ID_W-1:0]   q_id_r;
  logic [7:0]                 q_xhi_r, q_xlo_r;
  logic [obc_pkg::Y_W-1:0]    q_y_r;
  logic [BW-1:0]              q_w_r, q_h_r;
  logic                       qcap_r;

  obc_pkg::slot_t             slot_q_r;
  logic                       occ_a_r, a_vld_r;
  logic                       b_vld_r;
  logic [7:0]                 b_xlo_r;
  logic [obc_pkg::Y_W-1:0]    b_y_r;
  logic [2*BW-1:0]            size_q_r;
  logic                       kind_ok_r;

  logic [BW-1:0]              s_w, s_h;
  logic [7:0]                 e_q_x, e_q_y, e_s_x, e_s_y;
  logic                       pass;
  logic                       hit_acc_r;
  logic                       out_valid_r, out_hit_r;

  assign slot_idx_ok = ({1'b0, in_index} < 7'(ACTIVE_SLOTS));
  assign size_idx_ok = ({1'b0, in_index} < 7'(SIZE_DEPTH));
  assign size_rkind  = ctl.accept ? in_obj_kind : slot_q_r.kind;
  assign rkind_ok    = ({1'b0, size_rkind} < 7'(SIZE_DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.accept && (in_cmd == obc_pkg::CMD_LOAD_SLOT) && slot_idx_ok) begin
      slot_mem[in_index[SLOT_AW-1:0]] <= '{id: in_object_id, kind: in_obj_kind,
                                           x: in_pos_x, y: in_pos_y};
    end
    slot_q_r <= slot_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && (in_cmd == obc_pkg::CMD_LOAD_SIZE) && size_idx_ok) begin
      size_mem[in_index[SIZE_AW-1:0]] <= {in_box_width, in_box_height};
    end
    size_q_r  <= size_mem[size_rkind[SIZE_AW-1:0]];
    kind_ok_r <= rkind_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (ctl.accept && (in_cmd == obc_pkg::CMD_LOAD_SLOT) && slot_idx_ok) begin
      occ_r[in_index[SLOT_AW-1:0]] <= in_occupied;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      ptr_r   <= '0;
      q_id_r  <= in_object_id;
      q_xhi_r <= in_pos_x[15:8];
      q_xlo_r <= in_pos_x[7:0];
      q_y_r   <= in_pos_y;
    end else if (ctl.issue) begin
      ptr_r <= ptr_r + SLOT_AW'(1);
    end
    if (qcap_r) begin
      q_w_r <= kind_ok_r ? size_q_r[2*BW-1:BW] : '0;
      q_h_r <= kind_ok_r ? size_q_r[BW-1:0] : '0;
    end
    occ_a_r <= occ_r[ptr_r];
    b_xlo_r <= slot_q_r.x[7:0];
    b_y_r   <= slot_q_r.y;
  end

  always_comb begin
    s_w   = kind_ok_r ? size_q_r[2*BW-1:BW] : '0;
    s_h   = kind_ok_r ? size_q_r[BW-1:0] : '0;
    e_q_x = q_w_r + q_xlo_r;
    e_q_y = q_h_r + q_y_r;
    e_s_x = s_w + b_xlo_r;
    e_s_y = s_h + b_y_r;
    pass  = (e_q_x >= b_xlo_r) && (e_q_y >= b_y_r) && (e_s_x >= q_xlo_r) && (e_s_y >= q_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcap_r      <= 1'b0;
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      hit_acc_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      qcap_r  <= ctl.start_query;
      a_vld_r <= ctl.issue;
      b_vld_r <= a_vld_r && occ_a_r && (slot_q_r.id != q_id_r) &&
                 (slot_q_r.x[15:8] == q_xhi_r);
      if (ctl.accept) begin
        hit_acc_r <= 1'b0;
      end else if (b_vld_r && pass) begin
        hit_acc_r <= 1'b1;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_hit_r <= hit_acc_r;
    end
  end

  assign sts.last_slot = (ptr_r == SLOT_AW'(ACTIVE_SLOTS - 1));
  assign sts.out_full  = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;

endmodule

// ----- src/object_box_collision_search.sv -----
// Object box collision search top level: obc_ctrl and obc_datapath behind two channels.
// A load beat goes straight from acceptance to the result state; a query walks the slot memory
// one slot per cycle, then passes ST_FLUSH1 and ST_FLUSH2 before the result state.
// One beat is in work at a time; the next is accepted once the result register is loaded.
// Synchronous active-low reset marks every slot unoccupied; the size store is undefined
// until written.
module object_box_collision_search #(
  parameter int ACTIVE_SLOTS = 16,
  parameter int TYPE_COUNT   = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  obc_in_if.sink        in_bus,
  obc_out_if.source     out_bus
);

  obc_pkg::ctl_t ctl;
  obc_pkg::sts_t sts;

  obc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_cmd    (in_bus.cmd),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .in_ready  (in_bus.ready),
    .ctl       (ctl)
  );

  obc_datapath #(
    .ACTIVE_SLOTS (ACTIVE_SLOTS),
    .TYPE_COUNT   (TYPE_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_cmd        (in_bus.cmd),
    .in_index      (in_bus.index),
    .in_object_id  (in_bus.object_id),
    .in_obj_kind   (in_bus.obj_kind),
    .in_occupied   (in_bus.occupied),
    .in_pos_x      (in_bus.pos_x),
    .in_pos_y      (in_bus.pos_y),
    .in_box_width  (in_bus.box_width),
    .in_box_height (in_bus.box_height),
    .out_ready     (out_bus.ready),
    .sts           (sts),
    .out_valid     (out_bus.valid),
    .out_hit       (out_bus.hit)
  );

endmodule

// ----- src/obc_checker.sv -----
// Port-level checker for object_box_collision_search, attached by the bind below.
// Depends only on the top level's channel signals.
module obc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("Result beat changed while stalled.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted while a beat is still in work.");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("Result appeared without a beat in work.");

endmodule

bind object_box_collision_search obc_checker u_obc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_hit   (out_bus.hit)
);

// ----- sim/tb.sv -----
// Testbench for object_box_collision_search: drives load, query and unused beats and
// checks every hit result against a predictor of the slot and size tables kept here.
// Depends on obc_pkg, the obc_in_if and obc_out_if interfaces, and the block's top level.
`timescale 1ns / 100ps

module tb;

  localparam int ID_W         = obc_pkg::ID_W;
  localparam int KIND_W       = obc_pkg::KIND_W;
  localparam int IDX_W        = obc_pkg::IDX_W;
  localparam int X_W          = obc_pkg::X_W;
  localparam int Y_W          = obc_pkg::Y_W;
  localparam int BOX_W        = obc_pkg::BOX_W;
  localparam int SLOT_COUNT   = 16;
  localparam int SLOT_AW      = $clog2(SLOT_COUNT);
  localparam int KIND_COUNT   = 64;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PRINT_CAP    = 50;

  typedef struct {
    obc_pkg::cmd_t     cmd;
    logic [IDX_W-1:0]  index;
    logic [ID_W-1:0]   object_id;
    logic [KIND_W-1:0] obj_kind;
    logic              occupied;
    logic [X_W-1:0]    pos_x;
    logic [Y_W-1:0]    pos_y;
    logic [BOX_W-1:0]  box_width;
    logic [BOX_W-1:0]  box_height;
  } beat_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic              live;
    logic [KIND_W-1:0] kind;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
  } slot_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  obc_in_if  in_bus();
  obc_out_if out_bus();

  object_box_collision_search #(
    .ACTIVE_SLOTS(SLOT_COUNT),
    .TYPE_COUNT  (KIND_COUNT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  slot_rec_t        slot_book [SLOT_COUNT];
  logic [BOX_W-1:0] kind_width [KIND_COUNT];
  logic [BOX_W-1:0] kind_height [KIND_COUNT];
  bit               pending_hits[$];
  int               error_count = 0;
  int               cycle_count = 0;
  int               hold_left = 0;
  int               burst_left = 0;
  logic [7:0]       screen_pool [4] = '{8'h00, 8'h01, 8'h80, 8'hFF};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch($sformatf("result beat hit=%b with nothing expected", out_bus.hit));
      end else if (out_bus.hit !== pending_hits[0]) begin
        report_mismatch($sformatf("hit=%b, expected %b", out_bus.hit, pending_hits[0]));
        void'(pending_hits.pop_front());
      end else begin
        void'(pending_hits.pop_front());
      end
    end
  end

  // The receiver follows a rotating stall mask, or holds ready low while hold_left runs.
  initial begin
    logic [15:0] stall_mask;
    int          pat_left;
    int          pat_pos;
    stall_mask = '1;
    pat_left = 0;
    pat_pos = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        if (pat_left == 0) begin
          stall_mask = 16'($urandom);
          if ($urandom_range(0, 3) == 0) stall_mask = '1;
          pat_left = $urandom_range(16, 64);
        end
        pat_left--;
        pat_pos = (pat_pos + 1) % 16;
        out_bus.ready <= stall_mask[pat_pos];
      end
    end
  end

  function automatic bit predict_collision(input logic [ID_W-1:0] qid,
                                           input logic [KIND_W-1:0] qkind,
                                           input logic [X_W-1:0] qx,
                                           input logic [Y_W-1:0] qy);
    logic [7:0] q_right;
    logic [7:0] q_bottom;
    logic [7:0] s_right;
    logic [7:0] s_bottom;
    slot_rec_t  e;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      e = slot_book[s];
      if (e.live && e.id != qid && e.x[15:8] == qx[15:8]) begin
        q_right  = kind_width[qkind] + qx[7:0];
        q_bottom = kind_height[qkind] + qy;
        s_right  = kind_width[e.kind] + e.x[7:0];
        s_bottom = kind_height[e.kind] + e.y;
        if (q_right >= e.x[7:0] && q_bottom >= e.y && s_right >= qx[7:0] && s_bottom >= qy)
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_beat(input beat_t b);
    bit hit;
    hit = 1'b0;
    unique case (b.cmd)
      obc_pkg::CMD_LOAD_SLOT: begin
        if (b.index < SLOT_COUNT) begin
          slot_book[b.index[SLOT_AW-1:0]].id   = b.object_id;
          slot_book[b.index[SLOT_AW-1:0]].live = b.occupied;
          slot_book[b.index[SLOT_AW-1:0]].kind = b.obj_kind;
          slot_book[b.index[SLOT_AW-1:0]].x    = b.pos_x;
          slot_book[b.index[SLOT_AW-1:0]].y    = b.pos_y;
        end
      end
      obc_pkg::CMD_LOAD_SIZE: begin
        if (b.index < KIND_COUNT) begin
          kind_width[b.index]  = b.box_width;
          kind_height[b.index] = b.box_height;
        end
      end
      obc_pkg::CMD_QUERY: hit = predict_collision(b.object_id, b.obj_kind, b.pos_x, b.pos_y);
      default: hit = 1'b0;
    endcase
    pending_hits.push_back(hit);
  endtask

  task automatic send_beat(input beat_t b);
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= b.cmd;
    in_bus.index      <= b.index;
    in_bus.object_id  <= b.object_id;
    in_bus.obj_kind   <= b.obj_kind;
    in_bus.occupied   <= b.occupied;
    in_bus.pos_x      <= b.pos_x;
    in_bus.pos_y      <= b.pos_y;
    in_bus.box_width  <= b.box_width;
    in_bus.box_height <= b.box_height;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_beat(b);
  endtask

  task automatic idle_sender(input int cycles);
    in_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) idle_sender(gap);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  function automatic beat_t make_beat(input obc_pkg::cmd_t cmd, input int idx, input int id,
                                      input int kind, input int occ, input int x,
                                      input int y, input int w, input int h);
    beat_t b;
    b.cmd        = cmd;
    b.index      = IDX_W'(idx);
    b.object_id  = ID_W'(id);
    b.obj_kind   = KIND_W'(kind);
    b.occupied   = 1'(occ);
    b.pos_x      = X_W'(x);
    b.pos_y      = Y_W'(y);
    b.box_width  = BOX_W'(w);
    b.box_height = BOX_W'(h);
    return b;
  endfunction

  // Most traffic is slot loads and queries aimed near a loaded slot, so hits and
  // near misses both occur; fields that a command ignores stay random.
  function automatic beat_t random_beat();
    beat_t     b;
    slot_rec_t e;
    int        pick;
    int        off;
    b = make_beat(obc_pkg::CMD_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      b.cmd = obc_pkg::CMD_LOAD_SLOT;
      b.index = (pick < 22) ? IDX_W'($urandom_range(0, SLOT_COUNT - 1)) :
                              IDX_W'($urandom_range(SLOT_COUNT, 63));
      if ($urandom_range(0, 3) != 0) b.object_id = ID_W'($urandom_range(0, 7));
      b.occupied = ($urandom_range(0, 6) != 0);
      if ($urandom_range(0, 4) != 0) b.pos_x[15:8] = screen_pool[$urandom_range(0, 3)];
    end else if (pick < 33) begin
      b.cmd = obc_pkg::CMD_LOAD_SIZE;
      if ($urandom_range(0, 3) != 0) begin
        b.box_width  = BOX_W'($urandom_range(0, 48));
        b.box_height = BOX_W'($urandom_range(0, 48));
      end
    end else if (pick < 95) begin
      e = slot_book[$urandom_range(0, SLOT_COUNT - 1)];
      if ($urandom_range(0, 3) != 0) b.object_id = ID_W'($urandom_range(0, 7));
      if ($urandom_range(0, 4) != 0) b.pos_x[15:8] = e.x[15:8];
      off = $urandom_range(0, 64) - 32;
      b.pos_x[7:0] = 8'(e.x[7:0] + off);
      off = $urandom_range(0, 64) - 32;
      b.pos_y = Y_W'(e.y + off);
    end else begin
      b.cmd = obc_pkg::CMD_UNUSED;
    end
    return b;
  endfunction

  task automatic reset_block();
    for (int s = 0; s < SLOT_COUNT; s++) slot_book[s] = '{default: '0};
    for (int k = 0; k < KIND_COUNT; k++) begin
      kind_width[k]  = '0;
      kind_height[k] = '0;
    end
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.cmd        <= obc_pkg::CMD_UNUSED;
    in_bus.index      <= '0;
    in_bus.object_id  <= '0;
    in_bus.obj_kind   <= '0;
    in_bus.occupied   <= 1'b0;
    in_bus.pos_x      <= '0;
    in_bus.pos_y      <= '0;
    in_bus.box_width  <= '0;
    in_bus.box_height <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Every size entry is written before any query, so no unwritten entry is ever read.
  task automatic test_size_store_fill();
    int pick;
    int w;
    int h;
    for (int k = 0; k < KIND_COUNT; k++) begin
      pick = $urandom_range(0, 9);
      w = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(4, 48);
      h = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(4, 48);
      pace_sender();
      send_beat(make_beat(obc_pkg::CMD_LOAD_SIZE, k, $urandom, $urandom, $urandom, $urandom,
                          $urandom, w, h));
    end
  endtask

  task automatic test_empty_table();
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 3, 5, 1, 16'h0000, 8'h00, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_special_cases();
    send_beat(make_beat(obc_pkg::CMD_LOAD_SIZE, 1, 0, 0, 0, 0, 0, 16, 16));
    send_beat(make_beat(obc_pkg::CMD_LOAD_SIZE, 2, 0, 0, 0, 0, 0, 255, 255));
    send_beat(make_beat(obc_pkg::CMD_LOAD_SIZE, 63, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_LOAD_SLOT, 0, 5, 1, 1, 16'h0310, 8'h20, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 9, 1, 0, 16'h0318, 8'h28, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 5, 1, 0, 16'h0318, 8'h28, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 9, 1, 0, 16'h0418, 8'h28, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 9, 1, 0, 16'h0321, 8'h28, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_LOAD_SLOT, 16, 7, 1, 1, 16'h0318, 8'h28, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_LOAD_SLOT, 63, 7, 1, 1, 16'h0318, 8'h28, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_LOAD_SLOT, 0, 5, 1, 0, 16'h0310, 8'h20, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 9, 1, 0, 16'h0318, 8'h28, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_LOAD_SLOT, 15, 255, 63, 1, 16'hFFFF, 8'hFF, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 0, 63, 0, 16'hFFFF, 8'hFF, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 0, 2, 0, 16'hFF01, 8'hFF, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 0, 1, 0, 16'hFFF0, 8'hF0, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_UNUSED, 63, 255, 63, 1, 16'hFFFF, 8'hFF, 255, 255));
    send_beat(make_beat(obc_pkg::CMD_LOAD_SLOT, 0, 0, 0, 1, 16'h0000, 8'h00, 255, 255));
    send_beat(make_beat(obc_pkg::CMD_QUERY, 0, 1, 0, 0, 16'h0000, 8'h00, 0, 0));
    send_beat(make_beat(obc_pkg::CMD_LOAD_SIZE, 63, 255, 63, 1, 16'hFFFF, 8'hFF, 255, 255));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      pace_sender();
      send_beat(random_beat());
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_receiver_hold();
    wait_for_drain();
    hold_left <= 300;
    for (int i = 0; i < 10; i++) send_beat(random_beat());
    wait_for_drain();
  endtask

  task automatic test_drain_between_bursts();
    for (int r = 0; r < 3; r++) begin
      test_random_traffic(20);
      wait_for_drain();
      idle_sender($urandom_range(0, 5));
    end
  endtask

  initial begin
    reset_block();
    test_size_store_fill();
    test_empty_table();
    test_special_cases();
    test_random_traffic(520);
    test_receiver_hold();
    test_drain_between_bursts();
    wait_for_drain();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
